// File: src/life_board_engine_top_macros.svh
// ----------------------------------------------------------------------------
// Life board engine assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LIFE_BOARD_ENGINE_TOP_MACROS_SVH
`define LIFE_BOARD_ENGINE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LBE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LBE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/lbe_pkg.sv
// ----------------------------------------------------------------------------
// Life board engine package
// Field widths, command codes, controller states and the control interface.
// ----------------------------------------------------------------------------
package lbe_pkg;

   localparam int SIZE_W      = 7;
   localparam int POS_W       = 6;
   localparam int CMD_W       = 2;
   localparam int CELL_W      = 5;
   localparam int COUNT_W     = 4;
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 8;
   localparam int CSR_INDEX_W = 4;
   localparam int MIN_SIZE    = 3;

   localparam logic [CSR_INDEX_W-1:0] REG_BOARD_WIDTH  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_BOARD_HEIGHT = CSR_INDEX_W'(1);

   localparam logic [COUNT_W-1:0] COUNT_KEEP  = COUNT_W'(2);
   localparam logic [COUNT_W-1:0] COUNT_BIRTH = COUNT_W'(3);
   localparam logic [COUNT_W-1:0] COUNT_UP    = COUNT_W'(1);
   localparam logic [COUNT_W-1:0] COUNT_DOWN  = '1;

   typedef enum logic [CMD_W-1:0] {
      OP_SET     = 2'd0,
      OP_CLEAR   = 2'd1,
      OP_ADVANCE = 2'd2,
      OP_READ    = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD_ISSUE,
      ST_RD_CAPTURE,
      ST_CT_RD,
      ST_CT_WR,
      ST_NB_RD,
      ST_NB_WR,
      ST_COPY,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic clear_write;
      logic load_req;
      logic rd_target;
      logic capture_read;
      logic use_nb;
      logic center_write;
      logic nb_start;
      logic nb_write;
      logic copy_read;
      logic scan_read;
      logic scan_target;
      logic rsp_load;
   } lbe_cmd_type;

   typedef struct packed {
      logic   sweep_last;
      op_type req_op;
      logic   req_oor;
      logic   redundant;
      logic   nb_last;
      logic   adv;
      logic   scan_end;
      logic   scan_change;
      logic   rsp_free;
   } lbe_status_type;

endpackage

// File: src/lbe_ram.sv
// ----------------------------------------------------------------------------
// Life board engine RAM
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module lbe_ram #(
   parameter int WIDTH = 5,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/lbe_ctrl.sv
// ----------------------------------------------------------------------------
// Life board engine controller
// Sequences clearing, commands, the snapshot copy and the generation scan.
// ----------------------------------------------------------------------------
`include "life_board_engine_top_macros.svh"

module lbe_ctrl
   import lbe_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  lbe_status_type status,
   output lbe_cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;
   state_type after_update;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      if (status.adv && !status.scan_end) begin
         after_update = ST_SCAN_RD;
      end else begin
         after_update = ST_FINISH;
      end
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_write = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               if (status.req_op == OP_ADVANCE) begin
                  state_in = ST_COPY;
               end else if (status.req_oor) begin
                  state_in = ST_FINISH;
               end else if (status.req_op == OP_READ) begin
                  state_in = ST_RD_ISSUE;
               end else begin
                  state_in = ST_CT_RD;
               end
            end
         end
         ST_RD_ISSUE: begin
            cmd.rd_target = 1'b1;
            state_in      = ST_RD_CAPTURE;
         end
         ST_RD_CAPTURE: begin
            cmd.capture_read = 1'b1;
            state_in         = ST_FINISH;
         end
         ST_CT_RD: begin
            cmd.rd_target = 1'b1;
            state_in      = ST_CT_WR;
         end
         ST_CT_WR: begin
            if (status.redundant) begin
               state_in = after_update;
            end else begin
               cmd.center_write = 1'b1;
               cmd.nb_start     = 1'b1;
               state_in         = ST_NB_RD;
            end
         end
         ST_NB_RD: begin
            cmd.rd_target = 1'b1;
            cmd.use_nb    = 1'b1;
            state_in      = ST_NB_WR;
         end
         ST_NB_WR: begin
            cmd.use_nb   = 1'b1;
            cmd.nb_write = 1'b1;
            if (status.nb_last) begin
               state_in = after_update;
            end else begin
               state_in = ST_NB_RD;
            end
         end
         ST_COPY: begin
            cmd.copy_read = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: begin
            cmd.scan_read = 1'b1;
            state_in      = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            if (status.scan_change) begin
               cmd.scan_target = 1'b1;
               state_in        = ST_CT_RD;
            end else if (status.scan_end) begin
               state_in = ST_FINISH;
            end else begin
               cmd.scan_read = 1'b1;
            end
         end
         ST_FINISH: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   `LBE_ASSERT_NEXT(a_accept_leaves_idle, req_tvalid && req_tready, state_ff != ST_IDLE, "accepted word did not start work")
   `LBE_ASSERT_NOW(a_center_after_read, cmd.center_write, $past(cmd.rd_target), "center write without a fresh read")
   `LBE_ASSERT_NOW(a_target_after_scan, cmd.scan_target, $past(cmd.scan_read), "scan decision without snapshot data")

endmodule

// File: src/lbe_datapath.sv
// ----------------------------------------------------------------------------
// Life board engine datapath
// Size registers, cell and snapshot stores, neighbour walk and result word.
// ----------------------------------------------------------------------------
`include "life_board_engine_top_macros.svh"

module lbe_datapath
   import lbe_pkg::*;
#(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lbe_cmd_type            cmd,
   output lbe_status_type         status,
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [SIZE_W-1:0]      csr_data,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   output logic                   rsp_tuser
);

   localparam int CELLS  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = $clog2(CELLS);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);

   function automatic logic [ADDR_W-1:0] slot(input logic [SIZE_W-1:0] x,
                                              input logic [SIZE_W-1:0] y);
      logic [31:0] lin;
      lin = 32'(y) * 32'(MAX_WIDTH) + 32'(x);
      return lin[ADDR_W-1:0];
   endfunction

   logic [SIZE_W-1:0]  width_ff, width_in, height_ff, height_in;
   logic [ADDR_W-1:0]  sweep_ff, sweep_in, copy_addr_ff, copy_addr_in;
   logic               copy_pend_ff, copy_pend_in;
   logic [SIZE_W-1:0]  tx_ff, tx_in, ty_ff, ty_in;
   logic [SIZE_W-1:0]  sx_ff, sx_in, sy_ff, sy_in, cx_ff, cx_in, cy_ff, cy_in;
   logic               op_set_ff, op_set_in, adv_ff, adv_in, scan_end_ff, scan_end_in;
   logic [1:0]         ni_ff, ni_in, nj_ff, nj_in;
   logic               alive_ff, alive_in, oor_ff, oor_in, rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               rsp_alive_ff, rsp_alive_in, rsp_oor_ff, rsp_oor_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic [SIZE_W-1:0]  eff_w, eff_h;
   op_type             req_op;
   logic [SIZE_W-1:0]  req_x, req_y;
   logic               req_oor;
   logic [SIZE_W-1:0]  xm, xp, ym, yp, nbx, nby, ax, ay;
   logic [ADDR_W-1:0]  cell_addr, scan_addr;
   logic               cell_we, cell_re;
   logic [CELL_W-1:0]  cell_wdata, cell_rdata, snap_rdata;
   logic [COUNT_W-1:0] nb_count, snap_n;
   logic               last_x, last_y;

   always_comb begin
      if (width_ff < SIZE_W'(MIN_SIZE)) begin
         eff_w = SIZE_W'(MIN_SIZE);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         eff_w = SIZE_W'(MAX_WIDTH);
      end else begin
         eff_w = width_ff;
      end
      if (height_ff < SIZE_W'(MIN_SIZE)) begin
         eff_h = SIZE_W'(MIN_SIZE);
      end else if (32'(height_ff) > 32'(MAX_HEIGHT)) begin
         eff_h = SIZE_W'(MAX_HEIGHT);
      end else begin
         eff_h = height_ff;
      end
   end

   assign req_op  = op_type'(req_tdata[CMD_W-1:0]);
   assign req_x   = SIZE_W'(req_tdata[CMD_W +: POS_W]);
   assign req_y   = SIZE_W'(req_tdata[CMD_W + POS_W +: POS_W]);
   assign req_oor = (req_op != OP_ADVANCE) && ((req_x >= eff_w) || (req_y >= eff_h));

   assign xm = (tx_ff == '0) ? eff_w - SIZE_W'(1) : tx_ff - SIZE_W'(1);
   assign xp = (tx_ff + SIZE_W'(1) >= eff_w) ? '0 : tx_ff + SIZE_W'(1);
   assign ym = (ty_ff == '0) ? eff_h - SIZE_W'(1) : ty_ff - SIZE_W'(1);
   assign yp = (ty_ff + SIZE_W'(1) >= eff_h) ? '0 : ty_ff + SIZE_W'(1);

   always_comb begin
      case (ni_ff)
         2'd0:    nbx = xm;
         2'd1:    nbx = tx_ff;
         default: nbx = xp;
      endcase
      case (nj_ff)
         2'd0:    nby = ym;
         2'd1:    nby = ty_ff;
         default: nby = yp;
      endcase
   end

   assign ax        = cmd.use_nb ? nbx : tx_ff;
   assign ay        = cmd.use_nb ? nby : ty_ff;
   assign cell_addr = slot(ax, ay);
   assign scan_addr = slot(sx_ff, sy_ff);

   assign nb_count = cell_rdata[CELL_W-1:1] + (op_set_ff ? COUNT_UP : COUNT_DOWN);
   assign cell_we  = cmd.clear_write || cmd.center_write || cmd.nb_write;
   assign cell_re  = cmd.copy_read || cmd.rd_target;

   always_comb begin
      if (cmd.clear_write) begin
         cell_wdata = '0;
      end else if (cmd.center_write) begin
         cell_wdata = {cell_rdata[CELL_W-1:1], op_set_ff};
      end else begin
         cell_wdata = {nb_count, cell_rdata[0]};
      end
   end

   lbe_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (cell_we),
      .wr_addr (cmd.clear_write ? sweep_ff : cell_addr),
      .wr_data (cell_wdata),
      .rd_en   (cell_re),
      .rd_addr (cmd.copy_read ? sweep_ff : cell_addr),
      .rd_data (cell_rdata)
   );

   lbe_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_snap_ram (
      .clock   (clock),
      .wr_en   (copy_pend_ff),
      .wr_addr (copy_addr_ff),
      .wr_data (cell_rdata),
      .rd_en   (cmd.scan_read),
      .rd_addr (scan_addr),
      .rd_data (snap_rdata)
   );

   assign snap_n = snap_rdata[CELL_W-1:1];
   assign last_x = (sx_ff == eff_w - SIZE_W'(1));
   assign last_y = (sy_ff == eff_h - SIZE_W'(1));

   always_comb begin
      width_in     = width_ff;
      height_in    = height_ff;
      sweep_in     = sweep_ff;
      copy_pend_in = cmd.copy_read;
      copy_addr_in = sweep_ff;
      tx_in        = tx_ff;
      ty_in        = ty_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      op_set_in    = op_set_ff;
      adv_in       = adv_ff;
      scan_end_in  = scan_end_ff;
      ni_in        = ni_ff;
      nj_in        = nj_ff;
      alive_in     = alive_ff;
      count_in     = count_ff;
      oor_in       = oor_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_alive_in = rsp_alive_ff;
      rsp_count_in = rsp_count_ff;
      rsp_oor_in   = rsp_oor_ff;

      if (csr_write && csr_index == REG_BOARD_WIDTH) begin
         width_in = csr_data;
      end
      if (csr_write && csr_index == REG_BOARD_HEIGHT) begin
         height_in = csr_data;
      end
      if (cmd.clear_write || cmd.copy_read) begin
         sweep_in = (sweep_ff == LAST_ADDR) ? '0 : sweep_ff + ADDR_W'(1);
      end
      if (cmd.load_req) begin
         tx_in     = req_x;
         ty_in     = req_y;
         sx_in     = '0;
         sy_in     = '0;
         op_set_in = (req_op == OP_SET);
         adv_in    = (req_op == OP_ADVANCE);
         alive_in  = 1'b0;
         count_in  = '0;
         oor_in    = req_oor;
      end
      if (cmd.scan_read) begin
         cx_in       = sx_ff;
         cy_in       = sy_ff;
         scan_end_in = last_x && last_y;
         if (last_x) begin
            sx_in = '0;
            sy_in = sy_ff + SIZE_W'(1);
         end else begin
            sx_in = sx_ff + SIZE_W'(1);
         end
      end
      if (cmd.scan_target) begin
         tx_in     = cx_ff;
         ty_in     = cy_ff;
         op_set_in = !snap_rdata[0];
      end
      if (cmd.nb_start) begin
         ni_in = 2'd0;
         nj_in = 2'd0;
      end else if (cmd.nb_write) begin
         if (ni_ff == 2'd2) begin
            ni_in = 2'd0;
            nj_in = nj_ff + 2'd1;
         end else if (ni_ff == 2'd0 && nj_ff == 2'd1) begin
            ni_in = 2'd2;
         end else begin
            ni_in = ni_ff + 2'd1;
         end
      end
      if (cmd.capture_read) begin
         alive_in = cell_rdata[0];
         count_in = cell_rdata[CELL_W-1:1];
      end
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_alive_in = alive_ff;
         rsp_count_in = count_ff;
         rsp_oor_in   = oor_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= SIZE_W'(64);
         height_ff    <= SIZE_W'(64);
         sweep_ff     <= '0;
         copy_pend_ff <= 1'b0;
         adv_ff       <= 1'b0;
         scan_end_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         sweep_ff     <= sweep_in;
         copy_pend_ff <= copy_pend_in;
         adv_ff       <= adv_in;
         scan_end_ff  <= scan_end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      copy_addr_ff <= copy_addr_in;
      tx_ff        <= tx_in;
      ty_ff        <= ty_in;
      sx_ff        <= sx_in;
      sy_ff        <= sy_in;
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      op_set_ff    <= op_set_in;
      ni_ff        <= ni_in;
      nj_ff        <= nj_in;
      alive_ff     <= alive_in;
      count_ff     <= count_in;
      oor_ff       <= oor_in;
      rsp_alive_ff <= rsp_alive_in;
      rsp_count_ff <= rsp_count_in;
      rsp_oor_ff   <= rsp_oor_in;
   end

   always_comb begin
      status             = '0;
      status.sweep_last  = (sweep_ff == LAST_ADDR);
      status.req_op      = req_op;
      status.req_oor     = req_oor;
      status.redundant   = (cell_rdata[0] == op_set_ff);
      status.nb_last     = (ni_ff == 2'd2) && (nj_ff == 2'd2);
      status.adv         = adv_ff;
      status.scan_end    = scan_end_ff;
      status.scan_change = snap_rdata[0] ? (snap_n != COUNT_KEEP && snap_n != COUNT_BIRTH)
                                         : (snap_n == COUNT_BIRTH);
      status.rsp_free    = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - 1 - COUNT_W){1'b0}}, rsp_count_ff, rsp_alive_ff};
   assign rsp_tuser  = rsp_oor_ff;

   `LBE_ASSERT_NOW(a_nb_skips_center, cmd.nb_write, !(ni_ff == 2'd1 && nj_ff == 2'd1), "neighbour walk reached the center cell")
   `LBE_ASSERT_NEXT(a_rsp_held, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "waiting result word changed")

endmodule

// File: src/life_board_engine_top.sv
// ----------------------------------------------------------------------------
// Life board engine
// Toroidal Life board with cached neighbour counts, set, clear, read and
// advance-one-generation commands.
//
//   Channel  Direction  Payload
//   req_     in         tdata: command, x_pos, y_pos
//   rsp_     out        tdata: cell_alive, neighbour_count; tuser: out_of_range
//   csr_     in         index 0 board_width, 1 board_height; data 7 bits
//
// An advance copies all MAX_WIDTH*MAX_HEIGHT cells to the snapshot at one per
// cycle, then scans the board at one cell per cycle, pausing to update each
// cell that changes, all on the single read and write port of the cell store.
// After reset a clearing pass over all MAX_WIDTH*MAX_HEIGHT cells runs before the
// first word is taken. One word is in work at a time; a result waiting on
// rsp_tready holds only the finish of the next word.
// ----------------------------------------------------------------------------
module life_board_engine_top
   import lbe_pkg::*;
#(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // command, x_pos, y_pos, zero pad
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // cell_alive, neighbour_count, zero pad
   output logic                   rsp_tuser,   // out_of_range
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [SIZE_W-1:0]      csr_data
);

   lbe_cmd_type    cmd;
   lbe_status_type status;
   logic           csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   lbe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lbe_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// File: verif/life_board_engine_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Life board engine testbench
// Drives set, clear, read and advance words into the engine over several
// board sizes, including sizes below and above the legal range, and checks
// every result word against a board model kept inside this bench. Both
// stream sides idle in short random bursts, the result side is held off once
// for a long stretch, and the size registers are rewritten between phases
// while live cells remain on the board.
// ----------------------------------------------------------------------------
module life_board_engine_top_test;
   import lbe_pkg::*;

   localparam int BOARD_MAX = 64;
   localparam int BOARD_CELLS = BOARD_MAX * BOARD_MAX;
   localparam logic [CSR_INDEX_W-1:0] REG_TOP_SPARE = '1;

   typedef struct packed {
      logic [POS_W-1:0] y;
      logic [POS_W-1:0] x;
      op_type           op;
   } life_word_type;

   typedef struct packed {
      logic               alive;
      logic [COUNT_W-1:0] count;
      logic               oor;
   } cell_report_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [SIZE_W-1:0]      csr_data = '0;

   life_word_type   words_due[$];
   cell_report_type reports_due[$];
   life_word_type   req_word;
   int              req_gap = 0;
   int              rsp_gap = 0;
   int              words_taken = 0;
   int              fault_count = 0;
   logic            calm = 1'b0;
   logic            rsp_hold = 1'b0;

   logic               board_live [BOARD_CELLS];
   logic [COUNT_W-1:0] board_nbrs [BOARD_CELLS];
   logic               snap_live [BOARD_CELLS];
   logic [COUNT_W-1:0] snap_nbrs [BOARD_CELLS];
   logic [SIZE_W-1:0]  cfg_width_raw = SIZE_W'(BOARD_MAX);
   logic [SIZE_W-1:0]  cfg_height_raw = SIZE_W'(BOARD_MAX);

   life_board_engine_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   initial begin
      for (int k = 0; k < BOARD_CELLS; k++) begin
         board_live[k] = 1'b0;
         board_nbrs[k] = '0;
         snap_live[k] = 1'b0;
         snap_nbrs[k] = '0;
      end
   end

   function automatic int clamp_span(input logic [SIZE_W-1:0] raw);
      int v;
      v = int'(raw);
      if (v < MIN_SIZE) v = MIN_SIZE;
      if (v > BOARD_MAX) v = BOARD_MAX;
      return v;
   endfunction

   function automatic void shift_ring(input int x, input int y, input int w, input int h,
                                      input logic [COUNT_W-1:0] delta);
      int xs[3];
      int ys[3];
      int k;
      xs[0] = (x == 0) ? w - 1 : x - 1;
      xs[1] = x;
      xs[2] = (x + 1 >= w) ? 0 : x + 1;
      ys[0] = (y == 0) ? h - 1 : y - 1;
      ys[1] = y;
      ys[2] = (y + 1 >= h) ? 0 : y + 1;
      for (int j = 0; j < 3; j++) begin
         for (int i = 0; i < 3; i++) begin
            if (i != 1 || j != 1) begin
               k = (ys[j] * BOARD_MAX + xs[i]) % BOARD_CELLS;
               board_nbrs[k] = board_nbrs[k] + delta;
            end
         end
      end
   endfunction

   function automatic void bring_alive(input int x, input int y, input int w, input int h);
      int k;
      k = (y * BOARD_MAX + x) % BOARD_CELLS;
      if (!board_live[k]) begin
         board_live[k] = 1'b1;
         shift_ring(x, y, w, h, COUNT_UP);
      end
   endfunction

   function automatic void bring_dead(input int x, input int y, input int w, input int h);
      int k;
      k = (y * BOARD_MAX + x) % BOARD_CELLS;
      if (board_live[k]) begin
         board_live[k] = 1'b0;
         shift_ring(x, y, w, h, COUNT_DOWN);
      end
   endfunction

   function automatic void next_generation(input int w, input int h);
      int k;
      snap_live = board_live;
      snap_nbrs = board_nbrs;
      for (int y = 0; y < h; y++) begin
         for (int x = 0; x < w; x++) begin
            k = y * BOARD_MAX + x;
            if (snap_live[k]) begin
               if (snap_nbrs[k] != COUNT_KEEP && snap_nbrs[k] != COUNT_BIRTH)
                  bring_dead(x, y, w, h);
            end else if (snap_nbrs[k] == COUNT_BIRTH) begin
               bring_alive(x, y, w, h);
            end
         end
      end
   endfunction

   function automatic cell_report_type apply_command(input life_word_type wd);
      cell_report_type r;
      int w;
      int h;
      int k;
      w = clamp_span(cfg_width_raw);
      h = clamp_span(cfg_height_raw);
      r = '0;
      if (wd.op == OP_ADVANCE) begin
         next_generation(w, h);
      end else if (int'(wd.x) >= w || int'(wd.y) >= h) begin
         r.oor = 1'b1;
      end else if (wd.op == OP_SET) begin
         bring_alive(int'(wd.x), int'(wd.y), w, h);
      end else if (wd.op == OP_CLEAR) begin
         bring_dead(int'(wd.x), int'(wd.y), w, h);
      end else begin
         k = int'(wd.y) * BOARD_MAX + int'(wd.x);
         r.alive = board_live[k];
         r.count = board_nbrs[k];
      end
      return r;
   endfunction

   always @(posedge clock) begin : drive_req
      life_word_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            reports_due.push_back(apply_command(req_word));
            words_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap != 0) begin
               req_tvalid <= 1'b0;
               req_gap <= req_gap - 1;
            end else if (words_due.size() != 0 && !calm && $urandom_range(0, 5) == 0) begin
               req_tvalid <= 1'b0;
               req_gap <= $urandom_range(0, 4);
            end else if (words_due.size() != 0) begin
               nxt = words_due.pop_front();
               req_word <= nxt;
               req_tdata <= REQ_DATA_W'(nxt);
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : watch_rsp
      cell_report_type want;
      cell_report_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_gap <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.alive = rsp_tdata[0];
            got.count = rsp_tdata[COUNT_W:1];
            got.oor = rsp_tuser;
            if (reports_due.size() == 0) begin
               if (fault_count < 10)
                  $display("%0t: result word with none expected: alive %0d count %0d oor %0d",
                           $realtime, got.alive, got.count, got.oor);
               fault_count++;
            end else begin
               want = reports_due.pop_front();
               if (want !== got) begin
                  if (fault_count < 10)
                     $display("%0t: mismatch: alive %0d/%0d count %0d/%0d oor %0d/%0d (exp/act)",
                              $realtime, want.alive, got.alive, want.count, got.count,
                              want.oor, got.oor);
                  fault_count++;
               end
            end
         end
         if (rsp_hold) begin
            rsp_tready <= 1'b0;
         end else if (rsp_gap != 0) begin
            rsp_tready <= 1'b0;
            rsp_gap <= rsp_gap - 1;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            rsp_gap <= $urandom_range(0, 4);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      wait (words_taken >= 30);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (400) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin
      #6000000;
      $display("status: fail");
      $finish;
   end

   task automatic put(input op_type op, input int x, input int y);
      life_word_type wd;
      wd.op = op;
      wd.x = POS_W'(x);
      wd.y = POS_W'(y);
      words_due.push_back(wd);
   endtask

   task automatic drain();
      while (words_due.size() != 0 || req_tvalid || reports_due.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [SIZE_W-1:0] val);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == REG_BOARD_WIDTH) cfg_width_raw = val;
      else if (idx == REG_BOARD_HEIGHT) cfg_height_raw = val;
      @(posedge clock);
   endtask

   task automatic queue_random(input int n, input int w, input int h);
      life_word_type wd;
      int pick;
      int hx;
      int hy;
      hx = 0;
      hy = 0;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 99);
         wd.x = POS_W'($urandom_range(0, BOARD_MAX - 1));
         wd.y = POS_W'($urandom_range(0, BOARD_MAX - 1));
         if (pick < 8) begin
            wd.op = OP_ADVANCE;
         end else if (pick < 16) begin
            wd.op = op_type'($urandom_range(0, 3));
         end else begin
            if ($urandom_range(0, 1) == 1) begin
               wd.x = POS_W'((hx + w - 1 + $urandom_range(0, 2)) % w);
               wd.y = POS_W'((hy + h - 1 + $urandom_range(0, 2)) % h);
            end else begin
               wd.x = POS_W'($urandom_range(0, w - 1));
               wd.y = POS_W'($urandom_range(0, h - 1));
            end
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
               wd.op = OP_SET;
               hx = int'(wd.x);
               hy = int'(wd.y);
            end else if (pick < 65) begin
               wd.op = OP_CLEAR;
            end else begin
               wd.op = OP_READ;
            end
         end
         words_due.push_back(wd);
      end
   endtask

   task automatic run_phase(input logic [SIZE_W-1:0] w_raw, input logic [SIZE_W-1:0] h_raw,
                            input int n, input bit last);
      drain();
      write_reg(REG_BOARD_WIDTH, w_raw);
      write_reg(REG_BOARD_HEIGHT, h_raw);
      write_reg(CSR_INDEX_W'($urandom_range(int'(REG_BOARD_HEIGHT) + 1, int'(REG_TOP_SPARE))),
                SIZE_W'($urandom_range(0, 127)));
      if (last) calm <= 1'b1;
      queue_random(n, clamp_span(w_raw), clamp_span(h_raw));
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      put(OP_READ, 0, 0);
      put(OP_SET, 0, 0);
      put(OP_SET, 63, 63);
      put(OP_READ, 0, 0);
      put(OP_READ, 63, 63);
      put(OP_SET, 0, 0);
      put(OP_READ, 1, 1);
      put(OP_CLEAR, 5, 5);
      put(OP_CLEAR, 63, 63);
      put(OP_READ, 0, 0);
      put(OP_SET, 10, 20);
      put(OP_SET, 11, 20);
      put(OP_SET, 12, 20);
      put(OP_ADVANCE, 63, 63);
      put(OP_READ, 11, 19);
      put(OP_READ, 11, 20);
      put(OP_READ, 10, 20);
      put(OP_READ, 63, 0);

      drain();
      write_reg(REG_BOARD_WIDTH, SIZE_W'(5));
      write_reg(REG_BOARD_HEIGHT, SIZE_W'(3));
      write_reg(REG_TOP_SPARE, '1);
      put(OP_SET, 4, 2);
      put(OP_READ, 4, 2);
      put(OP_SET, 5, 0);
      put(OP_READ, 0, 3);
      put(OP_CLEAR, 63, 63);
      put(OP_ADVANCE, 0, 0);
      put(OP_READ, 0, 0);

      run_phase(SIZE_W'(3), SIZE_W'(3), 14, 1'b0);
      run_phase(SIZE_W'(0), SIZE_W'(127), 14, 1'b0);
      run_phase(SIZE_W'(16), SIZE_W'(12), 16, 1'b0);
      run_phase(SIZE_W'(127), SIZE_W'(2), 14, 1'b0);
      run_phase(SIZE_W'(7), SIZE_W'(9), 14, 1'b0);
      run_phase(SIZE_W'(64), SIZE_W'(64), 14, 1'b0);
      run_phase(SIZE_W'(65), SIZE_W'(5), 14, 1'b0);
      run_phase(SIZE_W'(4), SIZE_W'(6), 14, 1'b1);

      drain();
      repeat (20) @(posedge clock);
      if (fault_count == 0 && reports_due.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+src
src/lbe_pkg.sv
src/lbe_ram.sv
src/lbe_ctrl.sv
src/lbe_datapath.sv
src/life_board_engine_top.sv
verif/life_board_engine_top_test.sv
